FILE: rtl/mpod_pkg.sv
// Shared constants, types and register codes of the median pitch onset detector.
package mpod_pkg;

  localparam int MAX_RADIUS = 16;
  localparam int FRAME_BITS = 20;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS;
  localparam int AGE_W      = $clog2(WIN_DEPTH);
  localparam int RANK_W     = AGE_W + 1;
  localparam int R_W        = $clog2(MAX_RADIUS + 1);

  localparam int RADIUS_W   = 5;
  localparam int PITCH_W    = 15;
  localparam int THRESH_W   = 15;
  localparam int OUT_W      = 21;
  localparam int CNT_W      = FRAME_BITS + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam int GROUP      = (WIN_DEPTH < 8) ? WIN_DEPTH : 8;
  localparam int NGROUP     = WIN_DEPTH / GROUP;
  localparam int GRP_W      = $clog2(GROUP + 1);

  localparam int OQ_DEPTH   = 4;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);
  localparam int PUSH_W     = 2;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(10);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(154);
  localparam logic [CNT_W-1:0]    FRAME_LIMIT  = CNT_W'(1) << FRAME_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = CFG_IDX_W'(0),
    REG_THRESH = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [AGE_W-1:0]   age_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    pitch_t value;
    age_t   age;
    logic   less;
  } cell_view_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   insert;
    pitch_t new_val;
    logic   old_less;
  } cell_ctl_t;

  // Step strobes of the rank unit.
  typedef struct packed {
    logic s1;
    logic s2;
  } rank_ctl_t;

  typedef struct packed {
    logic [OUT_W-1:0] onset_frame;
    logic             is_end;
  } out_word_t;

  localparam cell_view_t EDGE_LO = '{value: '0, age: '0, less: 1'b1};
  localparam cell_view_t EDGE_HI = '{value: '0, age: '0, less: 1'b0};

endpackage

FILE: rtl/mpod_in_if.sv
// Pitch frame input channel.
interface mpod_in_if;
  import mpod_pkg::*;
  logic   valid;
  logic   ready;
  pitch_t pitch;
  logic   last_frame;
  modport source (output valid, output pitch, output last_frame, input ready);
  modport sink (input valid, input pitch, input last_frame, output ready);
endinterface

FILE: rtl/mpod_out_if.sv
// Onset result output channel.
interface mpod_out_if;
  import mpod_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] onset_frame;
  logic             is_end;
  modport source (output valid, output onset_frame, output is_end, input ready);
  modport sink (input valid, input onset_frame, input is_end, output ready);
endinterface

FILE: rtl/mpod_cfg_if.sv
// Configuration register write channel.
interface mpod_cfg_if;
  import mpod_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mpod_cell.sv
// One cell of the sorted pitch chain: holds a pitch and its age in frames.
module mpod_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [mpod_pkg::AGE_W-1:0]     cell_idx,
  input  mpod_pkg::cell_ctl_t            ctl,
  input  mpod_pkg::cell_view_t           left,
  input  mpod_pkg::cell_view_t           right,
  input  logic                           below_old,
  output mpod_pkg::cell_view_t           view,
  output logic                           is_old,
  output logic                           at_or_below
);
  import mpod_pkg::*;

  pitch_t value;
  pitch_t value_next;
  age_t   age;
  age_t   age_next;
  logic   less;

  assign less        = value < ctl.new_val;
  assign is_old      = (age == AGE_W'(WIN_DEPTH - 1));
  assign at_or_below = below_old | is_old;
  assign view        = '{value: value, age: age, less: less};

  // Oldest entry leaves, new pitch lands in its sorted slot; cells in between slide.
  always_comb begin
    value_next = value;
    age_next   = age + 1'b1;
    if (ctl.old_less) begin
      if (at_or_below && less) begin
        if (right.less) begin
          value_next = right.value;
          age_next   = right.age + 1'b1;
        end else begin
          value_next = ctl.new_val;
          age_next   = '0;
        end
      end
    end else if (!below_old && !less) begin
      if (left.less) begin
        value_next = ctl.new_val;
        age_next   = '0;
      end else begin
        value_next = left.value;
        age_next   = left.age + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      age   <= cell_idx;
    end else if (ctl.insert) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

FILE: rtl/mpod_rank.sv
// Rank select over the sorted chain: picks the median among the youngest 2r entries.
module mpod_rank (
  input  logic                       clk,
  input  mpod_pkg::rank_ctl_t        ctl,
  input  mpod_pkg::cell_view_t       cells [mpod_pkg::WIN_DEPTH],
  input  logic [mpod_pkg::R_W-1:0]   r,
  output mpod_pkg::pitch_t           median
);
  import mpod_pkg::*;

  logic [RANK_W-1:0] two_r;
  logic              elig_c [WIN_DEPTH];
  logic [GRP_W-1:0]  pre_c  [WIN_DEPTH];
  logic [GRP_W-1:0]  cnt_c  [NGROUP];
  logic              elig_q [WIN_DEPTH];
  logic [GRP_W-1:0]  pre_q  [WIN_DEPTH];
  logic [GRP_W-1:0]  cnt_q  [NGROUP];
  pitch_t            pick;

  assign two_r = RANK_W'({r, 1'b0});

  // Step one: window membership and in-group running counts.
  always_comb begin
    logic [GRP_W-1:0] run;
    for (int g = 0; g < NGROUP; g++) begin
      run = '0;
      for (int m = 0; m < GROUP; m++) begin
        elig_c[g*GROUP+m] = {1'b0, cells[g*GROUP+m].age} < two_r;
        pre_c[g*GROUP+m]  = run;
        run = run + GRP_W'(elig_c[g*GROUP+m]);
      end
      cnt_c[g] = run;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1) begin
      elig_q <= elig_c;
      pre_q  <= pre_c;
      cnt_q  <= cnt_c;
    end
  end

  // Step two: add group offsets, find the member of rank r.
  always_comb begin
    logic [RANK_W-1:0] off;
    logic [RANK_W-1:0] total;
    off  = '0;
    pick = '0;
    for (int g = 0; g < NGROUP; g++) begin
      for (int m = 0; m < GROUP; m++) begin
        total = off + RANK_W'(pre_q[g*GROUP+m]);
        if (elig_q[g*GROUP+m] && (total == RANK_W'(r))) begin
          pick = pick | cells[g*GROUP+m].value;
        end
      end
      off = off + RANK_W'(cnt_q[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2) begin
      median <= pick;
    end
  end

endmodule

FILE: rtl/mpod_outq.sv
// Four-word result queue with a two-word push port.
module mpod_outq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mpod_pkg::PUSH_W-1:0]      push_n,
  input  mpod_pkg::out_word_t              push_a,
  input  mpod_pkg::out_word_t              push_b,
  output logic [mpod_pkg::OQ_CNT_W-1:0]    count,
  mpod_out_if.source                       onset_out
);
  import mpod_pkg::*;

  out_word_t            entries [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr;
  logic [OQ_PTR_W-1:0]  rd_ptr;
  logic                 pop;

  assign pop                   = onset_out.valid && onset_out.ready;
  assign onset_out.valid       = (count != '0);
  assign onset_out.onset_frame = entries[rd_ptr].onset_frame;
  assign onset_out.is_end      = entries[rd_ptr].is_end;

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      entries[wr_ptr] <= push_a;
    end
    if (push_n == PUSH_W'(2)) begin
      entries[wr_ptr + OQ_PTR_W'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push_n);
      rd_ptr <= rd_ptr + OQ_PTR_W'(pop);
      count  <= count + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
    end
  end

endmodule

FILE: rtl/median_pitch_onset_detector_unit.sv
// Median pitch onset detector. Each pitch frame word enters a chain of 2*MAX_RADIUS
// cells that keeps the most recent frames sorted by pitch, each cell tagged with its
// age; on acceptance the oldest entry drops out and the new pitch slides into its
// sorted slot. The median is then the entry of rank r among cells younger than 2r
// frames, found by a two-step registered rank unit, and the decide state compares
// it with the reference note and pushes onset words into a four-word result queue.
// A frame passes through insert, two rank steps and decide; the block takes a new
// frame word only after decide and when the result queue has room for two words.
// Results: onset 0 on the first frame of a sequence, an onset when the median
// moves past the threshold outside the hold-off, and the frame count with is_end
// set on the last frame. No clearing pass after reset.
module median_pitch_onset_detector_unit (
  input logic      clk,
  input logic      rst,
  mpod_in_if.sink  frame_in,
  mpod_out_if.source onset_out,
  mpod_cfg_if.sink cfg
);
  import mpod_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RANK,
    PICK,
    DECIDE
  } state_t;

  state_t                state;
  logic [RADIUS_W-1:0]   radius;
  logic [THRESH_W-1:0]   change_threshold;
  logic [CNT_W-1:0]      frame_count;
  pitch_t                reference_note;
  logic [CNT_W-1:0]      last_change_pos;
  logic                  cur_last;

  logic [R_W-1:0]        r_eff;
  logic                  accept;
  logic                  in_range;
  cell_ctl_t             cell_ctl;
  cell_view_t            views   [WIN_DEPTH];
  cell_view_t            left_v  [WIN_DEPTH];
  cell_view_t            right_v [WIN_DEPTH];
  logic                  is_old  [WIN_DEPTH];
  logic                  at_or_below [WIN_DEPTH];
  logic                  below   [WIN_DEPTH];
  logic                  old_less;
  rank_ctl_t             rank_ctl;
  pitch_t                median;

  logic [OQ_CNT_W-1:0]   oq_count;
  logic [PUSH_W-1:0]     push_n;
  out_word_t             push_a;
  out_word_t             push_b;

  logic                  eval;
  logic [CNT_W-1:0]      i_pos;
  logic [CNT_W-1:0]      count_after;
  pitch_t                diff;
  logic                  change;
  logic                  far;
  logic                  emit_first;
  logic                  emit_onset;
  logic                  emit_end;
  out_word_t             w_first;
  out_word_t             w_onset;
  out_word_t             w_end;

  // Clamp radius into 1..MAX_RADIUS.
  always_comb begin
    if (radius == '0) begin
      r_eff = R_W'(1);
    end else if (radius > RADIUS_W'(MAX_RADIUS)) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(radius);
    end
  end

  // Accept only when idle and the queue can take two words.
  assign frame_in.ready = (state == IDLE) && (oq_count <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign accept         = frame_in.valid && frame_in.ready;
  assign cfg.ready      = 1'b1;
  assign in_range       = frame_count < FRAME_LIMIT;

  // Past the frame limit the window holds still.
  always_comb begin
    old_less = 1'b0;
    for (int j = 0; j < WIN_DEPTH; j++) begin
      old_less = old_less | (is_old[j] && views[j].less);
    end
  end

  assign cell_ctl = '{insert: accept && in_range, new_val: frame_in.pitch,
                      old_less: old_less};

  // Sorted chain; ends see a virtual smaller cell below and a larger one above.
  for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_lo
      assign left_v[j] = EDGE_LO;
      assign below[j]  = 1'b0;
    end else begin : g_mid
      assign left_v[j] = views[j-1];
      assign below[j]  = at_or_below[j-1];
    end
    if (j == WIN_DEPTH - 1) begin : g_hi
      assign right_v[j] = EDGE_HI;
    end else begin : g_nxt
      assign right_v[j] = views[j+1];
    end

    mpod_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_idx    (AGE_W'(j)),
      .ctl         (cell_ctl),
      .left        (left_v[j]),
      .right       (right_v[j]),
      .below_old   (below[j]),
      .view        (views[j]),
      .is_old      (is_old[j]),
      .at_or_below (at_or_below[j])
    );
  end

  assign rank_ctl = '{s1: state == RANK, s2: state == PICK};

  mpod_rank u_rank (
    .clk    (clk),
    .ctl    (rank_ctl),
    .cells  (views),
    .r      (r_eff),
    .median (median)
  );

  // Decide frame k: evaluate position k-r+1 if k >= 2r-1, in range, not the last frame.
  always_comb begin
    eval        = !cur_last && in_range &&
                  (frame_count >= CNT_W'({r_eff, 1'b0} - 1'b1));
    i_pos       = frame_count - CNT_W'(r_eff) + CNT_W'(1);
    count_after = in_range ? frame_count + CNT_W'(1) : frame_count;
    diff        = (median > reference_note) ? median - reference_note
                                            : reference_note - median;
    change      = eval && (diff > change_threshold);
    far         = {1'b0, i_pos} > ({1'b0, last_change_pos} + (CNT_W+1)'(r_eff));
    emit_first  = (frame_count == '0);
    emit_onset  = change && far;
    emit_end    = cur_last;
    w_first     = '{onset_frame: '0, is_end: 1'b0};
    w_onset     = '{onset_frame: OUT_W'(i_pos), is_end: 1'b0};
    w_end       = '{onset_frame: OUT_W'(count_after), is_end: 1'b1};
    // Order: first-frame onset, median onset, end marker; never more than two.
    push_a      = emit_first ? w_first : (emit_onset ? w_onset : w_end);
    push_b      = (emit_first && emit_onset) ? w_onset : w_end;
    push_n      = (state == DECIDE) ?
                  ({1'b0, emit_first} + {1'b0, emit_onset} + {1'b0, emit_end}) : '0;
  end

  mpod_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (push_b),
    .count     (oq_count),
    .onset_out (onset_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      radius           <= RADIUS_RESET;
      change_threshold <= THRESH_RESET;
      frame_count      <= '0;
      reference_note   <= '0;
      last_change_pos  <= '0;
      cur_last         <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_RADIUS: radius           <= cfg.data[RADIUS_W-1:0];
          REG_THRESH: change_threshold <= cfg.data[THRESH_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            cur_last <= frame_in.last_frame;
            state    <= RANK;
          end
        end
        RANK: state <= PICK;
        PICK: state <= DECIDE;
        DECIDE: begin
          state <= IDLE;
          if (cur_last) begin
            // Drop sequence state so the next word opens a new sequence.
            frame_count     <= '0;
            reference_note  <= '0;
            last_change_pos <= '0;
          end else begin
            frame_count <= count_after;
            if (change) begin
              reference_note  <= median;
              last_change_pos <= i_pos;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/mpod_checker.sv
// Port-level checks of the onset detector, bound to the top level.
module mpod_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mpod_pkg::OUT_W-1:0]  out_onset_frame,
  input logic                        out_is_end
);
  import mpod_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_onset_frame) && $stable(out_is_end))
    else $error("result word changed while stalled");

  a_end_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_end |-> out_onset_frame != '0)
    else $error("end marker reports zero frames");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("frame word accepted while previous frame in flight");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word shown right after reset");

endmodule

bind median_pitch_onset_detector_unit mpod_checker u_mpod_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (frame_in.valid),
  .in_ready        (frame_in.ready),
  .out_valid       (onset_out.valid),
  .out_ready       (onset_out.ready),
  .out_onset_frame (onset_out.onset_frame),
  .out_is_end      (onset_out.is_end)
);

FILE: tb/testbench.sv
// Self-checking testbench for the median pitch onset detector unit.
module testbench;
  import mpod_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 600;

  typedef struct packed {
    pitch_t pitch;
    logic   last;
  } pitch_word_t;

  typedef enum logic [1:0] {
    SHAPE_STEPS,
    SHAPE_NOISE,
    SHAPE_FLAT,
    SHAPE_EXTREMES
  } seq_shape_t;

  logic clk;
  logic rst;

  mpod_in_if  frame_bus ();
  mpod_out_if onset_bus ();
  mpod_cfg_if cfg_bus ();

  median_pitch_onset_detector_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .frame_in  (frame_bus),
    .onset_out (onset_bus),
    .cfg       (cfg_bus)
  );

  // Pitch frames waiting for the driver, and onset words waiting for the monitor.
  pitch_word_t frames_pending[$];
  out_word_t   onset_words_due[$];

  // Predictor state: pitch ring indexed by frame number, sequence state, registers.
  pitch_t                pitch_ring[WIN_DEPTH];
  logic [CNT_W-1:0]      frame_cnt;
  pitch_t                ref_note;
  longint unsigned       chg_pos;
  logic [RADIUS_W-1:0]   radius_reg;
  logic [THRESH_W-1:0]   thresh_reg;

  // Run bookkeeping.
  int unsigned frames_queued;
  int unsigned frames_taken;
  int unsigned seq_cnt;
  int unsigned reg_writes;
  int unsigned onsets_seen;
  int unsigned ends_seen;
  int unsigned mismatch_cnt;

  // Idling control shared by the driver and the receiver.
  logic        idle_on;
  logic        hold_req;
  logic        in_taken;
  int unsigned snd_gap;
  int unsigned rcv_stall;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp the programmed radius the way the block does: zero acts as one,
  // anything past the window limit acts as the limit.
  function automatic int unsigned eff_radius();
    if (radius_reg == 0) return 1;
    if (radius_reg > MAX_RADIUS) return MAX_RADIUS;
    return radius_reg;
  endfunction

  // Upper middle of the 2r frames starting at frame number first.
  function automatic pitch_t window_median(input longint unsigned first, input int unsigned r);
    pitch_t          sorted[WIN_DEPTH];
    pitch_t          v;
    longint unsigned idx;
    int              a;
    int              b;
    for (a = 0; a < 2 * r; a++) begin
      idx = first + a;
      sorted[a] = pitch_ring[idx % WIN_DEPTH];
    end
    for (a = 1; a < 2 * r; a++) begin
      v = sorted[a];
      b = a;
      while (b > 0 && sorted[b-1] > v) begin
        sorted[b] = sorted[b-1];
        b--;
      end
      sorted[b] = v;
    end
    return sorted[r];
  endfunction

  // Advance the predictor by one accepted frame word and queue the onset words it causes.
  task automatic predict_frame(input pitch_t p, input logic last);
    logic [CNT_W-1:0] k;
    int unsigned      r;
    longint unsigned  i;
    pitch_t           med;
    int unsigned      diff;
    k = frame_cnt;
    r = eff_radius();
    // first frame of every sequence is an onset
    if (k == 0) onset_words_due.push_back('{onset_frame: '0, is_end: 1'b0});
    // past the frame limit the count holds and nothing is evaluated
    if (k < FRAME_LIMIT) begin
      pitch_ring[k[AGE_W-1:0]] = p;
      if (!last && k >= 2 * r - 1) begin
        i = k - r + 1;
        med = window_median(i - r, r);
        diff = (med > ref_note) ? med - ref_note : ref_note - med;
        if (diff > thresh_reg) begin
          // report only outside the hold-off after the previous change
          if (i > chg_pos + r)
            onset_words_due.push_back('{onset_frame: OUT_W'(i), is_end: 1'b0});
          ref_note = med;
          chg_pos  = i;
        end
      end
      frame_cnt = k + CNT_W'(1);
    end
    // last frame closes the sequence with the frame count
    if (last) begin
      onset_words_due.push_back('{onset_frame: OUT_W'(frame_cnt), is_end: 1'b1});
      frame_cnt = '0;
      ref_note  = '0;
      chg_pos   = 0;
    end
  endtask

  task automatic add_frame(input pitch_t p, input logic last);
    frames_pending.push_back('{pitch: p, last: last});
    frames_queued++;
    if (last) seq_cnt++;
  endtask

  // Queue one whole sequence: mostly held notes with jitter and jumps around the
  // threshold, sometimes pure noise, a flat line or hops between the pitch extremes.
  task automatic add_sequence(input int unsigned len);
    seq_shape_t  shape;
    int unsigned pick;
    int unsigned hold;
    int unsigned r;
    int          j;
    int          note;
    int          p;
    int          span;
    r    = eff_radius();
    pick = $urandom_range(0, 9);
    shape = (pick < 6) ? SHAPE_STEPS : (pick < 8) ? SHAPE_NOISE :
            (pick < 9) ? SHAPE_FLAT : SHAPE_EXTREMES;
    note = int'($urandom_range(0, 32767));
    span = int'(thresh_reg) + 2;
    hold = 0;
    for (j = 0; j < len; j++) begin
      case (shape)
        SHAPE_NOISE:    p = int'($urandom_range(0, 32767));
        SHAPE_FLAT:     p = note;
        SHAPE_EXTREMES: p = $urandom_range(0, 1) ? 32767 : 0;
        default: begin
          if (hold == 0) begin
            hold = $urandom_range(1, 3 * r);
            if ($urandom_range(0, 1)) note = int'($urandom_range(0, 32767));
            else note = note + int'($urandom_range(0, 2 * span)) - span;
            if (note < 0) note = 0;
            if (note > 32767) note = 32767;
          end
          hold--;
          p = note + int'($urandom_range(0, span / 3)) - span / 6;
        end
      endcase
      if (p < 0) p = 0;
      if (p > 32767) p = 32767;
      add_frame(pitch_t'(p), j == len - 1);
    end
  endtask

  // Queue whole sequences until about count frames are waiting; keep most short.
  task automatic add_random_frames(input int unsigned count);
    int unsigned start;
    int unsigned r;
    int unsigned pick;
    start = frames_queued;
    r     = eff_radius();
    while (frames_queued - start < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) add_sequence($urandom_range(1, 3));
      else if (pick < 19) add_sequence($urandom_range(1, 6 * r + 4));
      else add_sequence($urandom_range(6 * r, 12 * r));
    end
  endtask

  // Hold until every queued frame word is taken and every onset word has come,
  // then let the block finish any frame that owes no result.
  task automatic settle();
    do @(negedge clk);
    while (frames_taken != frames_queued || onset_words_due.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    case (idx)
      REG_RADIUS: radius_reg = value[RADIUS_W-1:0];
      REG_THRESH: thresh_reg = value[THRESH_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Radius write with junk in the unused upper data bits.
  task automatic write_radius(input logic [RADIUS_W-1:0] r);
    write_reg(REG_RADIUS, {(CFG_DATA_W-RADIUS_W)'($urandom_range(0, 1023)), r});
  endtask

  // Driver, sampling side: record the accepted frame word and predict its results.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= frame_bus.valid && frame_bus.ready;
      if (frame_bus.valid && frame_bus.ready) begin
        predict_frame(frame_bus.pitch, frame_bus.last_frame);
        frames_taken++;
      end
    end
  end

  // Driver, driving side: hold the word until taken, then idle in bursts or advance.
  always @(negedge clk) begin
    if (rst) begin
      frame_bus.valid = 1'b0;
    end else if (!frame_bus.valid || in_taken) begin
      if (snd_gap > 0) begin
        snd_gap--;
        frame_bus.valid = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snd_gap = $urandom_range(1, 8) - 1;
        frame_bus.valid = 1'b0;
      end else if (frames_pending.size() > 0) begin
        pitch_word_t w;
        w = frames_pending.pop_front();
        frame_bus.pitch      = w.pitch;
        frame_bus.last_frame = w.last;
        frame_bus.valid      = 1'b1;
      end else begin
        frame_bus.valid = 1'b0;
      end
    end
  end

  // Receiver: a long hold-off on request, otherwise random stall bursts.
  always @(negedge clk) begin
    if (rst) begin
      onset_bus.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      onset_bus.ready = 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      onset_bus.ready = 1'b0;
    end else if (rcv_stall > 0) begin
      rcv_stall--;
      onset_bus.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rcv_stall = $urandom_range(1, 8) - 1;
      onset_bus.ready = 1'b0;
    end else begin
      onset_bus.ready = 1'b1;
    end
  end

  // Monitor: compare each taken onset word with the oldest one due.
  always @(posedge clk) begin
    if (!rst && onset_bus.valid && onset_bus.ready) begin
      if (onset_words_due.size() == 0) begin
        $display("%0t: unexpected word onset_frame %0d is_end %0b, none due",
                 $time, onset_bus.onset_frame, onset_bus.is_end);
        mismatch_cnt++;
      end else begin
        out_word_t due;
        due = onset_words_due.pop_front();
        if (onset_bus.onset_frame !== due.onset_frame) begin
          $display("%0t: onset_frame expected %0d, got %0d",
                   $time, due.onset_frame, onset_bus.onset_frame);
          mismatch_cnt++;
        end
        if (onset_bus.is_end !== due.is_end) begin
          $display("%0t: is_end expected %0b, got %0b", $time, due.is_end, onset_bus.is_end);
          mismatch_cnt++;
        end
        if (due.is_end) ends_seen++;
        else onsets_seen++;
      end
    end
  end

  // Timeout: end the run if it overruns a generous cycle budget.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d onset words still due", $time, onset_words_due.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int j;
    // Drive every input to a known value and clear the predictor.
    rst                  = 1'b1;
    frame_bus.valid      = 1'b0;
    frame_bus.pitch      = '0;
    frame_bus.last_frame = 1'b0;
    onset_bus.ready      = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = REG_RADIUS;
    cfg_bus.data         = '0;
    for (j = 0; j < WIN_DEPTH; j++) pitch_ring[j] = '0;
    frame_cnt     = '0;
    ref_note      = '0;
    chg_pos       = 0;
    radius_reg    = RADIUS_RESET;
    thresh_reg    = THRESH_RESET;
    frames_queued = 0;
    frames_taken  = 0;
    seq_cnt       = 0;
    reg_writes    = 0;
    onsets_seen   = 0;
    ends_seen     = 0;
    mismatch_cnt  = 0;
    idle_on       = 1'b1;
    hold_req      = 1'b0;
    snd_gap       = 0;
    rcv_stall     = 0;
    hold_left     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings. Directed: single-frame sequence at top pitch, then a
    // two-frame sequence from zero to the top.
    add_frame(pitch_t'(32767), 1'b1);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(32767), 1'b1);
    add_random_frames(250);
    settle();

    // Smallest radius, zero threshold: every change counts, hold-off of one frame.
    write_radius(RADIUS_W'(1));
    write_reg(REG_THRESH, '0);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(32767), 1'b0);
    add_frame(pitch_t'(32767), 1'b0);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(0), 1'b0);
    add_frame(pitch_t'(1), 1'b0);
    add_frame(pitch_t'(1), 1'b0);
    add_frame(pitch_t'(1), 1'b1);
    // Hold off the receiver while frames keep coming so the result queue fills
    // and the block stalls its input.
    hold_req = 1'b1;
    add_random_frames(250);
    settle();

    // Radius zero acts as one. Pause the sender partway into a sequence until
    // every onset word has come, then carry the same sequence on.
    write_radius(RADIUS_W'(0));
    write_reg(REG_THRESH, THRESH_W'(1));
    for (j = 0; j < 40; j++) add_frame(pitch_t'((j * 811) % 32768), 1'b0);
    settle();
    add_random_frames(200);
    settle();

    // Largest radius, threshold that no difference can exceed.
    write_radius(RADIUS_W'(MAX_RADIUS));
    write_reg(REG_THRESH, THRESH_W'(32767));
    add_random_frames(250);
    settle();

    // Radius above the window limit acts as the limit.
    write_radius(RADIUS_W'(31));
    write_reg(REG_THRESH, THRESH_W'(300));
    add_random_frames(250);
    settle();

    // Mid-range random settings.
    write_radius(RADIUS_W'($urandom_range(2, 15)));
    write_reg(REG_THRESH, THRESH_W'($urandom_range(0, 2000)));
    add_random_frames(250);
    settle();

    // Closing stretch with no idling on either side.
    write_radius(RADIUS_W'($urandom_range(1, MAX_RADIUS)));
    write_reg(REG_THRESH, THRESH_RESET);
    idle_on = 1'b0;
    add_random_frames(250);
    settle();

    $display("Ran %0d pitch frames in %0d sequences across %0d register writes",
             frames_queued, seq_cnt, reg_writes);
    $display("Checked %0d onset words and %0d end markers", onsets_seen, ends_seen);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
